// ===== hw/rtl/assert_macros.svh =====
// Assertion helpers used by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define ASSERT_AT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("assertion failed");
`define ASSERT_NEVER(lbl, clk, rst_n, expr) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
    else $error("assertion failed");
`else
`define ASSERT_AT(lbl, clk, rst_n, prop)
`define ASSERT_NEVER(lbl, clk, rst_n, expr)
`endif
`endif

// ===== hw/rtl/srp_pkg.sv =====
package srp_pkg;

  typedef enum logic [2:0] {
    PART_START,
    PART_NAME,
    PART_HREST,
    PART_SEQ,
    PART_SKIP
  } part_t;

  localparam logic [2:0] KIND_HCHAR = 3'd0;
  localparam logic [2:0] KIND_HEND  = 3'd1;
  localparam logic [2:0] KIND_BASE  = 3'd2;
  localparam logic [2:0] KIND_REND  = 3'd3;
  localparam logic [2:0] KIND_DROP  = 3'd4;
  localparam logic [2:0] KIND_ERR   = 3'd5;

  localparam logic [2:0] ERR_NONE         = 3'd0;
  localparam logic [2:0] ERR_EMPTY_HEADER = 3'd1;
  localparam logic [2:0] ERR_MISSING_AT   = 3'd2;
  localparam logic [2:0] ERR_MISSING_PLUS = 3'd3;
  localparam logic [2:0] ERR_EMPTY_SEQ    = 3'd4;
  localparam logic [2:0] ERR_NO_HEADER    = 3'd5;
  localparam logic [2:0] ERR_SEQ_FIRST    = 3'd6;

  localparam logic [7:0] CH_GT   = 8'h3E;
  localparam logic [7:0] CH_AT   = 8'h40;
  localparam logic [7:0] CH_PLUS = 8'h2B;
  localparam logic [7:0] CH_CR   = 8'h0D;
  localparam logic [7:0] CH_LF   = 8'h0A;
  localparam logic [7:0] CH_TAB  = 8'h09;
  localparam logic [7:0] CH_VT   = 8'h0B;
  localparam logic [7:0] CH_FF   = 8'h0C;
  localparam logic [7:0] CH_SP   = 8'h20;
  localparam logic [7:0] CH_A    = 8'h41;
  localparam logic [7:0] CH_C    = 8'h43;
  localparam logic [7:0] CH_G    = 8'h47;
  localparam logic [7:0] CH_T    = 8'h54;

  localparam logic [1:0] BASE_A = 2'd0;
  localparam logic [1:0] BASE_C = 2'd1;
  localparam logic [1:0] BASE_G = 2'd2;
  localparam logic [1:0] BASE_T = 2'd3;

  localparam logic [15:0] LFSR_TAPS  = 16'hB400;
  localparam logic [15:0] SEED_RESET = 16'hACE1;

  localparam logic REG_FORMAT = 1'b0;
  localparam logic REG_SEED   = 1'b1;

  localparam logic FMT_FASTA = 1'b0;

  typedef struct packed {
    logic [2:0]  kind;
    logic [7:0]  hchar;
    logic [1:0]  base;
    logic        repl;
    logic [2:0]  err;
    logic [31:0] line;
  } res_t;

  function automatic logic is_space(input logic [7:0] c);
    return (c == CH_SP) || (c == CH_TAB) || (c == CH_LF) || (c == CH_VT) ||
           (c == CH_FF) || (c == CH_CR);
  endfunction

endpackage

// ===== hw/rtl/sequence_record_parser_unit.sv =====
// With the result queue empty, a result appears on out_* in the cycle after its input
// transaction is accepted; a second result of the same input follows it out of the queue.
// Throughput: one input byte per cycle; the four-entry result queue is drained one result
// per cycle while out_tready is high, and the input stalls while more than two results
// wait or a register write is offered.
// Reset (rst_n low, synchronous): FASTA format, seed 0xACE1, parse state and queue cleared.
`include "assert_macros.svh"

module sequence_record_parser_unit #(
  parameter int LINE_COUNT_BITS = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] data_byte
  input  logic        in_tlast,   // end_of_input
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [47:0] out_tdata,  // [7:0] header_char, [9:8] base_code, [10] base_replaced,
                                  // [13:11] error_code, [45:14] line_number, [47:46] zero
  output logic [2:0]  out_tuser,  // [2:0] item_kind
  output logic        out_tlast,  // last_of_run
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [15:0] cfg_data
);

  localparam int LCB = LINE_COUNT_BITS;

  typedef struct packed {
    srp_pkg::part_t  part;
    logic [1:0]      quad;
    logic            name_started;
    logic            header_seen;
    logic            bases_seen;
    logic            halted;
    logic [15:0]     lfsr;
    logic [LCB-1:0]  lc;
    logic [1:0]      n;
    srp_pkg::res_t   r0;
    srp_pkg::res_t   r1;
  } ps_t;

  typedef struct packed {
    srp_pkg::res_t r;
    logic          last;
  } qent_t;

  function automatic srp_pkg::res_t mk(input logic [2:0] kind, input logic [7:0] hc,
                                       input logic [1:0] base, input logic repl,
                                       input logic [2:0] err, input logic [31:0] line);
    srp_pkg::res_t r;
    r.kind  = kind;
    r.hchar = hc;
    r.base  = base;
    r.repl  = repl;
    r.err   = err;
    r.line  = line;
    return r;
  endfunction

  function automatic ps_t emit(input ps_t s, input srp_pkg::res_t r);
    ps_t t;
    t = s;
    if (s.n == 2'd0) begin
      t.r0 = r;
    end else begin
      t.r1 = r;
    end
    t.n = s.n + 2'd1;
    return t;
  endfunction

  function automatic ps_t raise_err(input ps_t s, input logic [2:0] code);
    ps_t t;
    logic [63:0] lx;
    lx = 64'(s.lc);
    t = emit(s, mk(srp_pkg::KIND_ERR, 8'h00, 2'd0, 1'b0, code, lx[31:0]));
    t.halted = 1'b1;
    return t;
  endfunction

  function automatic ps_t put_base(input ps_t s, input logic [7:0] c);
    ps_t t;
    logic [1:0] code;
    logic repl;
    t = s;
    repl = 1'b0;
    if (c == srp_pkg::CH_A) begin
      code = srp_pkg::BASE_A;
    end else if (c == srp_pkg::CH_C) begin
      code = srp_pkg::BASE_C;
    end else if (c == srp_pkg::CH_G) begin
      code = srp_pkg::BASE_G;
    end else if (c == srp_pkg::CH_T) begin
      code = srp_pkg::BASE_T;
    end else begin
      t.lfsr = {1'b0, s.lfsr[15:1]} ^ (s.lfsr[0] ? srp_pkg::LFSR_TAPS : 16'h0000);
      code = t.lfsr[1:0];
      repl = 1'b1;
    end
    t.bases_seen = 1'b1;
    t = emit(t, mk(srp_pkg::KIND_BASE, 8'h00, code, repl, srp_pkg::ERR_NONE, 32'd0));
    return t;
  endfunction

  function automatic ps_t proc_char(input ps_t s, input logic [7:0] c, input logic fmt);
    ps_t t;
    t = s;
    if (!s.halted) begin
      case (s.part)
        srp_pkg::PART_START: begin
          if (fmt == srp_pkg::FMT_FASTA) begin
            if (c == srp_pkg::CH_GT) begin
              if (s.header_seen && !s.bases_seen) begin
                t = raise_err(t, srp_pkg::ERR_EMPTY_SEQ);
              end else begin
                if (s.header_seen) begin
                  t = emit(t, mk(srp_pkg::KIND_REND, 8'h00, 2'd0, 1'b0,
                                 srp_pkg::ERR_NONE, 32'd0));
                end
                t.header_seen  = 1'b1;
                t.bases_seen   = 1'b0;
                t.name_started = 1'b0;
                t.part         = srp_pkg::PART_NAME;
              end
            end else if (!s.header_seen) begin
              t = raise_err(t, srp_pkg::ERR_SEQ_FIRST);
            end else begin
              t.part = srp_pkg::PART_SEQ;
              t = put_base(t, c);
            end
          end else begin
            case (s.quad)
              2'd0: begin
                if (c == srp_pkg::CH_AT) begin
                  t.name_started = 1'b0;
                  t.part = srp_pkg::PART_NAME;
                end else begin
                  t = raise_err(t, srp_pkg::ERR_MISSING_AT);
                end
              end
              2'd1: begin
                t.part = srp_pkg::PART_SEQ;
                t = put_base(t, c);
              end
              2'd2: begin
                if (c == srp_pkg::CH_PLUS) begin
                  t.part = srp_pkg::PART_SKIP;
                end else begin
                  t = raise_err(t, srp_pkg::ERR_MISSING_PLUS);
                end
              end
              default: begin
                t.part = srp_pkg::PART_SKIP;
              end
            endcase
          end
        end
        srp_pkg::PART_NAME: begin
          if (srp_pkg::is_space(c)) begin
            if (s.name_started) begin
              t = emit(t, mk(srp_pkg::KIND_HEND, 8'h00, 2'd0, 1'b0,
                             srp_pkg::ERR_NONE, 32'd0));
              t.part = srp_pkg::PART_HREST;
            end else begin
              t = raise_err(t, srp_pkg::ERR_EMPTY_HEADER);
            end
          end else begin
            t = emit(t, mk(srp_pkg::KIND_HCHAR, c, 2'd0, 1'b0, srp_pkg::ERR_NONE, 32'd0));
            t.name_started = 1'b1;
          end
        end
        srp_pkg::PART_SEQ: begin
          t = put_base(t, c);
        end
        default: begin
        end
      endcase
    end
    return t;
  endfunction

  function automatic ps_t end_line(input ps_t s, input logic fmt);
    ps_t t;
    t = s;
    if (!s.halted) begin
      if (s.part == srp_pkg::PART_START) begin
        if (fmt != srp_pkg::FMT_FASTA) begin
          if (s.quad == 2'd1) begin
            t = emit(t, mk(srp_pkg::KIND_DROP, 8'h00, 2'd0, 1'b0, srp_pkg::ERR_NONE, 32'd0));
          end
          t.quad = s.quad + 2'd1;
        end
      end else if (s.part == srp_pkg::PART_NAME && !s.name_started) begin
        t = raise_err(t, srp_pkg::ERR_EMPTY_HEADER);
      end else begin
        if (s.part == srp_pkg::PART_NAME) begin
          t = emit(t, mk(srp_pkg::KIND_HEND, 8'h00, 2'd0, 1'b0, srp_pkg::ERR_NONE, 32'd0));
        end
        if (s.part == srp_pkg::PART_SEQ && fmt != srp_pkg::FMT_FASTA) begin
          t = emit(t, mk(srp_pkg::KIND_REND, 8'h00, 2'd0, 1'b0, srp_pkg::ERR_NONE, 32'd0));
        end
        if (fmt != srp_pkg::FMT_FASTA) begin
          t.quad = s.quad + 2'd1;
        end
        if (s.lc != {LCB{1'b1}}) begin
          t.lc = s.lc + LCB'(1);
        end
        t.part = srp_pkg::PART_START;
      end
    end
    return t;
  endfunction

  logic            fmt_r;
  logic [15:0]     seed_r;
  ps_t             st_r;
  logic            pend_r;
  ps_t             st_nxt;
  logic            pend_nxt;
  logic [15:0]     seed_fix;
  logic            in_fire;
  logic            out_fire;
  logic            cfg_fire;
  qent_t           q_r [4];
  logic [1:0]      wr_ptr_r;
  logic [1:0]      rd_ptr_r;
  logic [2:0]      cnt_r;
  logic [2:0]      cnt_nxt;
  qent_t           out_ent;

  assign in_tready = (cnt_r <= 3'd2) && !cfg_valid;
  assign in_fire   = in_tvalid && in_tready;
  assign out_fire  = out_tvalid && out_tready;
  assign cfg_ready = 1'b1;
  assign cfg_fire  = cfg_valid && cfg_ready;
  assign seed_fix  = (cfg_data == 16'h0000) ? 16'h0001 : cfg_data;

  always_comb begin
    ps_t s;
    logic pend;
    logic skip_b;
    s = st_r;
    s.n = 2'd0;
    s.r0 = '0;
    s.r1 = '0;
    pend = pend_r;
    skip_b = 1'b0;
    if (in_tlast) begin
      if (!s.halted) begin
        if (s.part != srp_pkg::PART_START) begin
          s = end_line(s, fmt_r);
        end
        if (fmt_r == srp_pkg::FMT_FASTA && !s.halted) begin
          if (!s.bases_seen) begin
            s = raise_err(s, srp_pkg::ERR_EMPTY_SEQ);
          end else if (!s.header_seen) begin
            s = raise_err(s, srp_pkg::ERR_NO_HEADER);
          end else begin
            s = emit(s, mk(srp_pkg::KIND_REND, 8'h00, 2'd0, 1'b0, srp_pkg::ERR_NONE, 32'd0));
          end
        end
      end
      s.part         = srp_pkg::PART_START;
      s.quad         = 2'd0;
      s.name_started = 1'b0;
      s.header_seen  = 1'b0;
      s.bases_seen   = 1'b0;
      s.halted       = 1'b0;
      s.lfsr         = seed_r;
      s.lc           = LCB'(1);
      pend           = 1'b0;
    end else if (!s.halted) begin
      if (pend) begin
        pend = 1'b0;
        if (in_tdata == srp_pkg::CH_LF) begin
          s = end_line(s, fmt_r);
          skip_b = 1'b1;
        end else begin
          s = proc_char(s, srp_pkg::CH_CR, fmt_r);
        end
      end
      if (!skip_b) begin
        if (in_tdata == srp_pkg::CH_CR) begin
          pend = 1'b1;
        end else if (in_tdata == srp_pkg::CH_LF) begin
          s = end_line(s, fmt_r);
        end else begin
          s = proc_char(s, in_tdata, fmt_r);
        end
      end
    end
    st_nxt = s;
    pend_nxt = pend;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fmt_r           <= srp_pkg::FMT_FASTA;
      seed_r          <= srp_pkg::SEED_RESET;
      st_r.part       <= srp_pkg::PART_START;
      st_r.quad       <= 2'd0;
      st_r.name_started <= 1'b0;
      st_r.header_seen  <= 1'b0;
      st_r.bases_seen   <= 1'b0;
      st_r.halted     <= 1'b0;
      st_r.lfsr       <= srp_pkg::SEED_RESET;
      st_r.lc         <= LCB'(1);
      st_r.n          <= 2'd0;
      st_r.r0         <= '0;
      st_r.r1         <= '0;
      pend_r          <= 1'b0;
    end else if (cfg_fire) begin
      if (cfg_index == srp_pkg::REG_FORMAT) begin
        fmt_r             <= cfg_data[0];
        st_r.part         <= srp_pkg::PART_START;
        st_r.quad         <= 2'd0;
        st_r.name_started <= 1'b0;
        st_r.header_seen  <= 1'b0;
        st_r.bases_seen   <= 1'b0;
        st_r.halted       <= 1'b0;
        st_r.lfsr         <= seed_r;
        st_r.lc           <= LCB'(1);
        pend_r            <= 1'b0;
      end else begin
        seed_r    <= seed_fix;
        st_r.lfsr <= seed_fix;
      end
    end else if (in_fire) begin
      st_r   <= st_nxt;
      pend_r <= pend_nxt;
    end
  end

  always_comb begin
    cnt_nxt = cnt_r;
    if (in_fire) begin
      cnt_nxt = cnt_nxt + {1'b0, st_nxt.n};
    end
    if (out_fire) begin
      cnt_nxt = cnt_nxt - 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 2'd0;
      rd_ptr_r <= 2'd0;
      cnt_r    <= 3'd0;
    end else begin
      cnt_r <= cnt_nxt;
      if (in_fire) begin
        wr_ptr_r <= wr_ptr_r + st_nxt.n;
      end
      if (out_fire) begin
        rd_ptr_r <= rd_ptr_r + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire && st_nxt.n != 2'd0) begin
      q_r[wr_ptr_r].r    <= st_nxt.r0;
      q_r[wr_ptr_r].last <= (st_nxt.n == 2'd1);
      if (st_nxt.n == 2'd2) begin
        q_r[wr_ptr_r + 2'd1].r    <= st_nxt.r1;
        q_r[wr_ptr_r + 2'd1].last <= 1'b1;
      end
    end
  end

  assign out_ent    = q_r[rd_ptr_r];
  assign out_tvalid = (cnt_r != 3'd0);
  assign out_tuser  = out_ent.r.kind;
  assign out_tlast  = out_ent.last;
  assign out_tdata  = {2'b00, out_ent.r.line, out_ent.r.err, out_ent.r.repl,
                       out_ent.r.base, out_ent.r.hchar};

  `ASSERT_NEVER(a_queue_overflow, clk, rst_n, cnt_r > 3'd4)
  `ASSERT_NEVER(a_lfsr_zero, clk, rst_n, st_r.lfsr == 16'h0000)
  `ASSERT_AT(a_halted_silent, clk, rst_n, (in_fire && st_r.halted && !in_tlast) |-> (st_nxt.n == 2'd0))
  `ASSERT_AT(a_error_is_last, clk, rst_n, (in_fire && st_nxt.n == 2'd2) |-> (st_nxt.r0.kind != srp_pkg::KIND_ERR))

endmodule
